/* rtl/core/casf_pkg.sv */
package casf_pkg;

   // Command codes: accumulator ALU group first, then the rotate/shift group.
   typedef enum logic [3:0] {
      CMD_ADD  = 4'd0,
      CMD_ADC  = 4'd1,
      CMD_SUB  = 4'd2,
      CMD_SBC  = 4'd3,
      CMD_AND  = 4'd4,
      CMD_XOR  = 4'd5,
      CMD_OR   = 4'd6,
      CMD_CP   = 4'd7,
      CMD_RLC  = 4'd8,
      CMD_RRC  = 4'd9,
      CMD_RL   = 4'd10,
      CMD_RR   = 4'd11,
      CMD_SLA  = 4'd12,
      CMD_SRA  = 4'd13,
      CMD_SWAP = 4'd14,
      CMD_SRL  = 4'd15
   } cmd_type;

   // Branch condition codes.
   typedef enum logic [1:0] {
      COND_NZ = 2'd0,
      COND_Z  = 2'd1,
      COND_NC = 2'd2,
      COND_C  = 2'd3
   } cond_type;

   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] operand;
      logic       shift_to_acc;
      cond_type   cond_sel;
   } req_type;

   typedef struct packed {
      logic [7:0] value;
      logic       zero_flag;
      logic       sub_flag;
      logic       half_flag;
      logic       carry_flag;
      logic       cond_met;
   } rsp_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   // Architectural state carried from one transaction to the next.
   typedef struct packed {
      logic [7:0] acc;
      flags_type  flags;
   } state_type;

endpackage

/* rtl/core/casf_exec.sv */
module casf_exec (
   input  casf_pkg::req_type   req,
   input  casf_pkg::state_type state_cur,
   output casf_pkg::rsp_type   rsp,
   output casf_pkg::state_type state_nxt
);
   import casf_pkg::*;

   logic [7:0] a;
   logic [7:0] b;
   logic       cin;
   logic       c_use;
   logic [8:0] sum9;
   logic [4:0] sum_lo;
   logic [8:0] dif9;
   logic [4:0] dif_lo;
   logic [7:0] res;
   logic       f_h;
   logic       f_c;
   logic       f_n;
   logic       f_z;
   logic       is_alu;
   logic       acc_we;
   logic       cond;

   assign a      = state_cur.acc;
   assign b      = req.operand;
   assign cin    = state_cur.flags.c;
   assign is_alu = ~req.cmd[3];

   // Carry-in only for the with-carry forms.
   assign c_use  = ((req.cmd == CMD_ADC) || (req.cmd == CMD_SBC)) ? cin : 1'b0;

   // Adder and subtractor with nibble carry/borrow taps.
   assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, c_use};
   assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_use};
   assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, c_use};
   assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_use};

   // Result byte and N/H/C for each command.
   always_comb begin
      res = BYTE_ZERO;
      f_n = 1'b0;
      f_h = 1'b0;
      f_c = 1'b0;
      unique case (req.cmd)
         CMD_ADD, CMD_ADC: begin
            res = sum9[7:0];
            f_h = sum_lo[4];
            f_c = sum9[8];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            res = dif9[7:0];
            f_n = 1'b1;
            f_h = dif_lo[4];
            f_c = dif9[8];
         end
         CMD_AND: begin
            res = a & b;
            f_h = 1'b1;
         end
         CMD_XOR: res = a ^ b;
         CMD_OR:  res = a | b;
         CMD_RLC: begin
            res = {b[6:0], b[7]};
            f_c = b[7];
         end
         CMD_RRC: begin
            res = {b[0], b[7:1]};
            f_c = b[0];
         end
         CMD_RL: begin
            res = {b[6:0], cin};
            f_c = b[7];
         end
         CMD_RR: begin
            res = {cin, b[7:1]};
            f_c = b[0];
         end
         CMD_SLA: begin
            res = {b[6:0], 1'b0};
            f_c = b[7];
         end
         CMD_SRA: begin
            res = {b[7], b[7:1]};
            f_c = b[0];
         end
         CMD_SWAP: res = {b[3:0], b[7:4]};
         CMD_SRL: begin
            res = {1'b0, b[7:1]};
            f_c = b[0];
         end
         default: res = BYTE_ZERO;
      endcase
   end

   assign f_z = (res == BYTE_ZERO);

   // Compare leaves the accumulator alone; shifts write it only on request.
   assign acc_we = is_alu ? (req.cmd != CMD_CP) : req.shift_to_acc;

   // Branch condition on the new flags.
   always_comb begin
      unique case (req.cond_sel)
         COND_NZ: cond = ~f_z;
         COND_Z:  cond = f_z;
         COND_NC: cond = ~f_c;
         COND_C:  cond = f_c;
         default: cond = 1'b0;
      endcase
   end

   assign state_nxt.acc     = acc_we ? res : a;
   assign state_nxt.flags.z = f_z;
   assign state_nxt.flags.n = f_n;
   assign state_nxt.flags.h = f_h;
   assign state_nxt.flags.c = f_c;

   // ALU commands report the accumulator, shifts report the shifted byte.
   assign rsp.value      = is_alu ? state_nxt.acc : res;
   assign rsp.zero_flag  = f_z;
   assign rsp.sub_flag   = f_n;
   assign rsp.half_flag  = f_h;
   assign rsp.carry_flag = f_c;
   assign rsp.cond_met   = cond;

endmodule

/* rtl/core/cpu_alu_shift_flags_unit.sv */
// Accumulator ALU and rotate/shift unit with Z/N/H/C flags.
// Request channel (req_valid, req_stall, req_data) carries one command per
// transaction: the command code, an operand byte, an accumulator-write
// enable for shifts and a branch condition select. Response channel
// (rsp_valid, rsp_stall, rsp_data) returns one transaction per request:
// the result byte, the four flags and the evaluated condition.
// A command is captured in the input register when it is accepted; the
// execute logic then writes the response register together with the
// accumulator and flags. Throughput is one transaction per cycle while
// the receiver does not stall; the accumulator/flag feedback closes within
// the single execute stage, so back-to-back commands see each other's results.
// When the receiver stalls, the response register holds and the input
// register fills; the request side then stalls until the response drains.
// Synchronous reset clears both valid bits, the accumulator and all flags.
module cpu_alu_shift_flags_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  casf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output casf_pkg::rsp_type rsp_data
);
   import casf_pkg::*;

   logic      in_valid_ff;
   req_type   in_req_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   state_type state_ff;
   rsp_type   rsp_in;
   state_type state_in;
   logic      advance;

   // Execute when a command waits and the response register is free.
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= req_data;
      end
   end

   casf_exec u_exec (
      .req       (in_req_ff),
      .state_cur (state_ff),
      .rsp       (rsp_in),
      .state_nxt (state_in)
   );

   // Response register and architectural state advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The flag register always matches the flags of the response on offer.
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff.flags == {rsp_ff.zero_flag, rsp_ff.sub_flag,
                                          rsp_ff.half_flag, rsp_ff.carry_flag}))
      else $error("flag register differs from delivered flags");

   // A compare never changes the accumulator.
   a_cp_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_req_ff.cmd == CMD_CP)) |=> (state_ff.acc == $past(state_ff.acc)))
      else $error("compare modified the accumulator");

   // Subtract-type commands set N.
   a_sub_sets_n: assert property (@(posedge clock) disable iff (reset)
      (advance && ((in_req_ff.cmd == CMD_SUB) || (in_req_ff.cmd == CMD_SBC) ||
                   (in_req_ff.cmd == CMD_CP))) |=> rsp_ff.sub_flag)
      else $error("subtract command did not set N");

   // Request stall only while a command is held in the input register.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with no pending command");

endmodule

/* tb/sv/tb.sv */
module tb;
   import casf_pkg::*;

   // One command waiting to be driven, with an optional request to let the
   // block drain completely before it is presented.
   typedef struct {
      req_type item;
      bit      drain_first;
   } queued_cmd_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   queued_cmd_type queued_cmds[$];
   rsp_type        pending_results[$];

   // Shadow copy of the architectural state.
   logic [7:0] acc_shadow = 8'h00;
   flags_type  flags_shadow = '0;

   int             error_count = 0;
   logic           req_fired = 1'b0;
   int             gap_left = 0;
   int             burst_left = 1;
   int             stall_phase = 0;
   stall_kind_type stall_mode = STALL_NONE;

   cpu_alu_shift_flags_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit.
   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

   // Executes one command on the shadow state and returns the response it should produce.
   task automatic execute_cmd(input req_type item, output rsp_type res);
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] r;
      logic       cin;
      logic       c_use;
      logic [4:0] nib_sum;
      logic [8:0] full_sum;
      logic       z;
      logic       n;
      logic       h;
      logic       c;
      logic       cond;
      a = acc_shadow;
      b = item.operand;
      cin = flags_shadow.c;
      c_use = (item.cmd == CMD_ADC || item.cmd == CMD_SBC) ? cin : 1'b0;
      n = 1'b0;
      h = 1'b0;
      c = 1'b0;
      r = 8'h00;
      case (item.cmd)
         CMD_ADD, CMD_ADC: begin
            nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, c_use};
            full_sum = {1'b0, a} + {1'b0, b} + {8'b0, c_use};
            h = nib_sum[4];
            c = full_sum[8];
            r = full_sum[7:0];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            n = 1'b1;
            h = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0, c_use}));
            c = ({1'b0, a} < ({1'b0, b} + {8'b0, c_use}));
            r = a - b - {7'b0, c_use};
         end
         CMD_AND: begin
            r = a & b;
            h = 1'b1;
         end
         CMD_XOR: r = a ^ b;
         CMD_OR: r = a | b;
         CMD_RLC: begin
            r = {b[6:0], b[7]};
            c = b[7];
         end
         CMD_RRC: begin
            r = {b[0], b[7:1]};
            c = b[0];
         end
         CMD_RL: begin
            r = {b[6:0], cin};
            c = b[7];
         end
         CMD_RR: begin
            r = {cin, b[7:1]};
            c = b[0];
         end
         CMD_SLA: begin
            r = {b[6:0], 1'b0};
            c = b[7];
         end
         CMD_SRA: begin
            r = {b[7], b[7:1]};
            c = b[0];
         end
         CMD_SWAP: r = {b[3:0], b[7:4]};
         default: begin
            r = {1'b0, b[7:1]};
            c = b[0];
         end
      endcase
      z = (r == 8'h00);

      // ALU commands report the accumulator; shifts report the shifted byte.
      if (item.cmd <= CMD_CP) begin
         if (item.cmd != CMD_CP) acc_shadow = r;
         res.value = acc_shadow;
      end else begin
         if (item.shift_to_acc) acc_shadow = r;
         res.value = r;
      end
      flags_shadow = '{z: z, n: n, h: h, c: c};

      case (item.cond_sel)
         COND_NZ: cond = !z;
         COND_Z: cond = z;
         COND_NC: cond = !c;
         default: cond = c;
      endcase
      res.zero_flag = z;
      res.sub_flag = n;
      res.half_flag = h;
      res.carry_flag = c;
      res.cond_met = cond;
   endtask

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", label, want, got);
         error_count++;
      end
   endtask

   task automatic push_item(input cmd_type cmd, input logic [7:0] operand,
                            input logic to_acc, input cond_type sel, input bit drain);
      queued_cmd_type entry;
      entry.item.cmd = cmd;
      entry.item.operand = operand;
      entry.item.shift_to_acc = to_acc;
      entry.item.cond_sel = sel;
      entry.drain_first = drain;
      queued_cmds.push_back(entry);
   endtask

   // Operands lean toward the byte and nibble boundaries.
   function automatic logic [7:0] pick_operand();
      logic [7:0] corners[8];
      corners = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0F, 8'hF0, 8'h01, 8'hFE};
      if ($urandom_range(0, 3) == 0) return corners[3'($urandom_range(0, 7))];
      return 8'($urandom_range(0, 255));
   endfunction

   // Monitor and predictor: check accepted responses, then model accepted requests.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type res;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no expectation: %0h", rsp_data);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("value", want.value, rsp_data.value);
               check_field("zero_flag", want.zero_flag, rsp_data.zero_flag);
               check_field("sub_flag", want.sub_flag, rsp_data.sub_flag);
               check_field("half_flag", want.half_flag, rsp_data.half_flag);
               check_field("carry_flag", want.carry_flag, rsp_data.carry_flag);
               check_field("cond_met", want.cond_met, rsp_data.cond_met);
            end
         end
         if (req_valid && !req_stall) begin
            execute_cmd(req_data, res);
            pending_results.push_back(res);
            req_fired <= 1'b1;
         end else begin
            req_fired <= 1'b0;
         end
      end else begin
         req_fired <= 1'b0;
      end
   end

   // Driver: bursts of commands separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (queued_cmds.size() == 0) begin
            req_valid <= 1'b0;
         end else if (queued_cmds[0].drain_first && pending_results.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            req_data <= queued_cmds[0].item;
            req_valid <= 1'b1;
            void'(queued_cmds.pop_front());
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12)
                                                       : $urandom_range(0, 3);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Receiver stall pattern: switches to a randomly chosen mode whenever its phase counter runs out.
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode <= stall_kind_type'($urandom_range(0, 3));
         stall_phase <= $urandom_range(16, 80);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_phase[2];
      endcase
   end

   // Stimulus, reset and end of run.
   initial begin
      // Directed part: every command, flag corners, carry-in use and each condition.
      push_item(CMD_ADD, 8'hFF, 1'b0, COND_NZ, 1'b0);
      push_item(CMD_ADD, 8'h01, 1'b0, COND_Z, 1'b0);
      push_item(CMD_ADC, 8'h0F, 1'b1, COND_NC, 1'b0);
      push_item(CMD_SUB, 8'h11, 1'b0, COND_C, 1'b0);
      push_item(CMD_SBC, 8'hFE, 1'b0, COND_Z, 1'b0);
      push_item(CMD_CP, 8'h00, 1'b1, COND_Z, 1'b0);
      push_item(CMD_AND, 8'hFF, 1'b0, COND_NZ, 1'b0);
      push_item(CMD_OR, 8'hA5, 1'b0, COND_NZ, 1'b0);
      push_item(CMD_XOR, 8'hA5, 1'b0, COND_Z, 1'b0);
      push_item(CMD_OR, 8'h80, 1'b0, COND_C, 1'b1);
      // Rotate into another register leaves the accumulator alone.
      push_item(CMD_RLC, 8'h80, 1'b0, COND_C, 1'b0);
      push_item(CMD_RL, 8'h00, 1'b0, COND_NZ, 1'b0);
      // Rotate of the accumulator shifts the operand, not the accumulator.
      push_item(CMD_RRC, 8'h01, 1'b1, COND_C, 1'b0);
      push_item(CMD_RR, 8'h00, 1'b1, COND_NZ, 1'b0);
      push_item(CMD_SLA, 8'h80, 1'b0, COND_Z, 1'b0);
      push_item(CMD_SRA, 8'h81, 1'b1, COND_C, 1'b0);
      // Swap with carry set beforehand must clear it.
      push_item(CMD_SWAP, 8'hF0, 1'b0, COND_NC, 1'b0);
      push_item(CMD_SRL, 8'h01, 1'b0, COND_Z, 1'b0);
      push_item(CMD_SRL, 8'hFF, 1'b1, COND_C, 1'b0);
      push_item(CMD_CP, 8'h7F, 1'b0, COND_Z, 1'b0);
      push_item(CMD_SWAP, 8'h00, 1'b1, COND_Z, 1'b0);
      push_item(CMD_ADC, 8'hFF, 1'b0, COND_C, 1'b0);
      push_item(CMD_SBC, 8'h00, 1'b0, COND_NC, 1'b0);

      // Random part, with a full drain every couple of hundred commands.
      for (int k = 0; k < 1200; k++) begin
         push_item(cmd_type'($urandom_range(0, 15)), pick_operand(),
                   1'($urandom_range(0, 1)), cond_type'($urandom_range(0, 3)),
                   (k % 200) == 199);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (queued_cmds.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/core/casf_pkg.sv
rtl/core/casf_exec.sv
rtl/core/cpu_alu_shift_flags_unit.sv
tb/sv/tb.sv
